// ----- rtl/core/rac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants of the return autocovariance unit
// Field widths, register indexes, and the command and status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rac_pkg;

	// Field widths of the channels.
	localparam int CLOSE_W     = 24;
	localparam int RET_W       = 25;
	localparam int LAG_W       = 3;
	localparam int ACV_W       = 57;
	localparam int WIN_W       = 8;
	localparam int FRAC_BITS   = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// Lags are capped at five; a run needs three returns.
	localparam logic [LAG_W-1:0] LAG_CAP     = 3'd5;
	localparam int               MIN_RETURNS = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BARS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG     = 1'b1;

	// Reset values of the registers.
	localparam logic [WIN_W-1:0] WINDOW_BARS_RST = 8'd200;
	localparam logic [LAG_W-1:0] MAX_LAG_RST     = 3'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic setup;
		logic mem_rd;
		logic mean_acc;
		logic lag_init;
		logic centre;
		logic mul_lo;
		logic mul_hi;
		logic finish;
		logic div_start;
		logic emit;
	} rac_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_short;
		logic cnt_zero;
		logic lag_go;
		logic div_done;
		logic out_free;
	} rac_sts_t;

endpackage

// ----- rtl/core/rac_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_div: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend by an unsigned divisor; the quotient is ready
// with a one-cycle done pulse once all DW quotient bits are shifted in.
// ----------------------------------------------------------------------------
module rac_div #(
	parameter int DW = 89,
	parameter int VW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    num_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dsr_q;
	logic [VW:0]      trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, num_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: bit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
			num_q <= {num_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- rtl/core/rac_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_dp: datapath of the return autocovariance unit
// Return ring, mean and lag accumulators, split multiplier, divider, result
// saturation and the output register.
// ----------------------------------------------------------------------------
module rac_dp #(
	parameter int RING_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rac_pkg::rac_cmd_t              cmd,
	output rac_pkg::rac_sts_t              sts,
	input  logic [rac_pkg::CLOSE_W-1:0]    close_price,
	input  logic                           cfg_we,
	input  logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rac_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rac_pkg::LAG_W-1:0]      lag_index,
	output logic [rac_pkg::ACV_W-1:0]      autocovariance,
	output logic                           is_last
);

	import rac_pkg::*;

	localparam int PW_A = $clog2(RING_DEPTH);
	localparam int HW   = $clog2(RING_DEPTH + 1);
	localparam int NW   = (HW > 9) ? HW : 9;
	localparam int SW   = RET_W + NW;
	localparam int CW   = SW + 2;
	localparam int LW   = CW / 2;
	localparam int UW   = CW - LW;
	localparam int PW   = 2 * CW;
	localparam int ACW  = PW + NW;
	localparam int DW   = ACW + FRAC_BITS;
	localparam int VW   = 3 * NW;

	localparam logic [PW_A-1:0]  LAST_ADDR = PW_A'(RING_DEPTH - 1);
	localparam logic [NW:0]      DEPTH_N   = (NW + 1)'(RING_DEPTH);
	localparam logic [ACV_W-1:0] POS_LIM   = {1'b0, {(ACV_W - 1){1'b1}}};
	localparam logic [ACV_W-1:0] NEG_LIM   = {1'b1, {(ACV_W - 1){1'b0}}};

	function automatic logic [PW_A-1:0] ptr_inc(input logic [PW_A-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	// Configuration and bar state.
	logic [WIN_W-1:0]   win_q;
	logic [LAG_W-1:0]   maxlag_q;
	logic [CLOSE_W-1:0] prev_q;
	logic               has_prev_q;
	logic [PW_A-1:0]    wp_q;
	logic [HW-1:0]      held_q;

	// Run state.
	logic [NW-1:0]      n_q;
	logic [2*NW-1:0]    nn_q;
	logic [LAG_W-1:0]   lags_q;
	logic [LAG_W-1:0]   lag_q;
	logic [PW_A-1:0]    base_q;
	logic [PW_A-1:0]    ptr_a_q;
	logic [PW_A-1:0]    ptr_b_q;
	logic [NW-1:0]      cnt_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [RET_W-1:0]    rd_a_q;
	logic signed [RET_W-1:0]    rd_b_q;
	logic signed [CW-1:0]       ca_q;
	logic signed [CW-1:0]       cb_q;
	logic signed [CW+LW:0]      plo_q;
	logic signed [CW+UW-1:0]    phi_q;
	logic signed [ACW-1:0]      acc_q;
	logic [VW-1:0]      d_q;
	logic               neg_q;

	// Output register.
	logic               out_valid_q;
	logic [LAG_W-1:0]   out_lag_q;
	logic [ACV_W-1:0]   out_acv_q;
	logic               out_last_q;

	logic signed [RET_W-1:0] ring_mem [RING_DEPTH];

	logic [NW-1:0]      win1;
	logic [NW-1:0]      n_c;
	logic [NW:0]        base_t;
	logic [PW_A-1:0]    base_c;
	logic [LAG_W-1:0]   nl;
	logic [PW_A:0]      off_t;
	logic               div_done;
	logic [DW-1:0]      quo;
	logic [ACW-1:0]     mag;
	logic [ACV_W-1:0]   sat_c;
	logic               more_lags;

	// Window length, oldest entry of the window and the next lag.
	assign win1   = NW'(win_q) + 1'b1;
	assign n_c    = (NW'(held_q) < win1) ? NW'(held_q) : win1;
	assign base_t = {1'b0, NW'(wp_q)} + DEPTH_N - {1'b0, n_c};
	assign base_c = (base_t >= DEPTH_N) ? PW_A'(base_t - DEPTH_N) : base_t[PW_A-1:0];
	assign nl     = lag_q + 1'b1;
	assign off_t  = {1'b0, base_q} + (PW_A + 1)'(nl);

	// Status towards the controller.
	assign more_lags    = ({1'b0, lag_q} + 4'd1 <= {1'b0, lags_q}) &&
	                      (n_q >= NW'(lag_q) + NW'(3));
	assign sts.n_short  = n_c < NW'(MIN_RETURNS);
	assign sts.cnt_zero = cnt_q == '0;
	assign sts.lag_go   = (nl <= lags_q) && (lag_q != LAG_CAP) &&
	                      (n_q >= NW'(nl) + NW'(2));
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= WINDOW_BARS_RST;
			maxlag_q <= MAX_LAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_BARS: win_q    <= cfg_data;
				REG_MAX_LAG:     maxlag_q <= cfg_data[LAG_W-1:0];
				default:         ;
			endcase
		end
	end

	// Bar state: previous close, write pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			has_prev_q <= 1'b0;
			wp_q       <= '0;
			held_q     <= '0;
		end else if (cmd.take) begin
			prev_q     <= close_price;
			has_prev_q <= 1'b1;
			if (has_prev_q) begin
				wp_q <= ptr_inc(wp_q);
				if (held_q != HW'(RING_DEPTH))
					held_q <= held_q + 1'b1;
			end
		end
	end

	// Return ring: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.take && has_prev_q)
			ring_mem[wp_q] <= $signed({1'b0, close_price}) - $signed({1'b0, prev_q});
		if (cmd.mem_rd) begin
			rd_a_q <= ring_mem[ptr_a_q];
			rd_b_q <= ring_mem[ptr_b_q];
		end
	end

	// Run control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q <= '0;
		end else if (cmd.setup) begin
			lag_q <= '0;
		end else if (cmd.lag_init) begin
			lag_q <= nl;
		end
	end

	// Arithmetic: window sum, centring, split products and accumulation.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			n_q     <= n_c;
			nn_q    <= n_c * n_c;
			lags_q  <= (maxlag_q > LAG_CAP) ? LAG_CAP : maxlag_q;
			base_q  <= base_c;
			ptr_a_q <= base_c;
			ptr_b_q <= base_c;
			cnt_q   <= n_c;
			sum_q   <= '0;
		end
		if (cmd.mem_rd) begin
			ptr_a_q <= ptr_inc(ptr_a_q);
			ptr_b_q <= ptr_inc(ptr_b_q);
			cnt_q   <= cnt_q - 1'b1;
		end
		if (cmd.mean_acc)
			sum_q <= sum_q + SW'(rd_a_q);
		if (cmd.lag_init) begin
			ptr_b_q <= base_q;
			ptr_a_q <= (off_t >= (PW_A + 1)'(RING_DEPTH)) ?
			           PW_A'(off_t - (PW_A + 1)'(RING_DEPTH)) : off_t[PW_A-1:0];
			cnt_q   <= n_q - NW'(nl);
			d_q     <= VW'(nn_q) * VW'(n_q - NW'(nl));
			acc_q   <= '0;
			phi_q   <= '0;
		end
		if (cmd.centre) begin
			ca_q <= CW'($signed({1'b0, n_q})) * CW'(rd_a_q) - CW'(sum_q);
			cb_q <= CW'($signed({1'b0, n_q})) * CW'(rd_b_q) - CW'(sum_q);
		end
		if (cmd.mul_lo) begin
			plo_q <= ca_q * $signed({1'b0, cb_q[LW-1:0]});
			acc_q <= acc_q + (ACW'(phi_q) <<< LW);
		end
		if (cmd.mul_hi) begin
			phi_q <= ca_q * $signed(cb_q[CW-1:LW]);
			acc_q <= acc_q + ACW'(plo_q);
		end
		if (cmd.finish)
			acc_q <= acc_q + (ACW'(phi_q) <<< LW);
		if (cmd.div_start)
			neg_q <= acc_q[ACW-1];
	end

	// Magnitude of the sum, scaled by the fraction bits, into the divider.
	assign mag = acc_q[ACW-1] ? ACW'(-acc_q) : ACW'(acc_q);

	rac_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({mag, {FRAC_BITS{1'b0}}}),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (quo)
	);

	// Saturate the truncated quotient into the signed result range.
	always_comb begin
		if (neg_q) begin
			if ((|quo[DW-1:ACV_W]) || (quo[ACV_W-1] && (|quo[ACV_W-2:0])))
				sat_c = NEG_LIM;
			else
				sat_c = ACV_W'(-quo[ACV_W-1:0]);
		end else begin
			if (|quo[DW-1:ACV_W-1])
				sat_c = POS_LIM;
			else
				sat_c = quo[ACV_W-1:0];
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_lag_q  <= lag_q;
			out_acv_q  <= sat_c;
			out_last_q <= !more_lags;
		end
	end

	assign out_valid      = out_valid_q;
	assign lag_index      = out_lag_q;
	assign autocovariance = out_acv_q;
	assign is_last        = out_last_q;

	// The fill count never passes the ring depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	// The fill count does not grow on the first bar, which writes no return.
	a_held_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !has_prev_q) |=> $stable(held_q))
		else $error("fill count moved on the first bar");

	// A result always carries a lag from one to the cap.
	a_lag_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_lag_q >= 3'd1) && (out_lag_q <= LAG_CAP))
		else $error("result lag out of range");

endmodule

// ----- rtl/core/rac_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_ctrl: controller of the return autocovariance unit
// Steps the datapath through the mean pass, one accumulation pass per lag,
// the division and the hand-over of each result.
// ----------------------------------------------------------------------------
module rac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output rac_pkg::rac_cmd_t cmd,
	input  rac_pkg::rac_sts_t sts
);

	import rac_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_MRD   = 4'd2;
	localparam logic [3:0] S_MACC  = 4'd3;
	localparam logic [3:0] S_LCHK  = 4'd4;
	localparam logic [3:0] S_LINIT = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_CEN   = 4'd7;
	localparam logic [3:0] S_ML    = 4'd8;
	localparam logic [3:0] S_MH    = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_DIVS  = 4'd11;
	localparam logic [3:0] S_DIVW  = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.n_short ? S_IDLE : S_MRD;
			end
			S_MRD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_MACC;
			end
			S_MACC: begin
				cmd.mean_acc = 1'b1;
				state_d      = sts.cnt_zero ? S_LCHK : S_MRD;
			end
			S_LCHK: begin
				state_d = sts.lag_go ? S_LINIT : S_IDLE;
			end
			S_LINIT: begin
				cmd.lag_init = 1'b1;
				state_d      = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_CEN;
			end
			S_CEN: begin
				cmd.centre = 1'b1;
				state_d    = S_ML;
			end
			S_ML: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MH;
			end
			S_MH: begin
				cmd.mul_hi = 1'b1;
				state_d    = sts.cnt_zero ? S_FIN : S_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_LCHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// A transfer is only taken while idle.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == S_SETUP))
		else $error("transfer taken outside idle");

	// The divider is only waited on after it was started.
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVW) |-> ($past(state_q) == S_DIVS || $past(state_q) == S_DIVW))
		else $error("divider wait without start");

	// A result is only handed over once the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwrote a pending transfer");

endmodule

// ----- rtl/core/return_autocovariance_window_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// return_autocovariance_window_unit: sample autocovariance of bar returns
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// One closing price arrives per transfer on the s_axis channel. From the
// second bar on, the return against the previous close is written into a
// ring of RING_DEPTH entries. With n = min(window_bars + 1, returns held)
// and n at least three, the unit emits on m_axis one transfer per lag from
// one to min(max_lag, 5), stopping where n - lag falls below two; tlast marks
// the final transfer of a bar. Registers are written on the cfg port; the user
// must write them only while idle; the unit itself does not enforce this.
// Run: the mean pass reads each return of the window once; each lag then
// accumulates its products through the shared split multiplier and runs
// the bit-serial divider. A new price is taken only once the previous
// bar's run is done.
// Reset clears the previous close, the ring pointer, the fill count and both
// registers to their defaults; the ring contents need no clearing. A stalled
// receiver holds the current result in the output register; the run goes on
// and waits before the next hand-over until that transfer completes.
// ----------------------------------------------------------------------------
module return_autocovariance_window_unit #(
	parameter int RING_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [23:0] close_price
	input  logic [rac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [2:0] lag_index, [59:3] autocovariance, [63:60] zero
	output logic [rac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [rac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rac_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import rac_pkg::*;

	rac_cmd_t             cmd;
	rac_sts_t             sts;
	logic [LAG_W-1:0]     lag_index;
	logic [ACV_W-1:0]     autocovariance;

	rac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rac_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.close_price    (s_axis_tdata[CLOSE_W-1:0]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.lag_index      (lag_index),
		.autocovariance (autocovariance),
		.is_last        (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - ACV_W - LAG_W){1'b0}}, autocovariance, lag_index};

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the return autocovariance window unit
// Closing prices are streamed into the unit while the register settings are
// changed between phases. Every accepted bar is run through a behavioural
// autocovariance calculator, and each result transfer is compared field by
// field against the oldest outstanding expectation. The sender works in
// bursts with gaps and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
	import rac_pkg::*;

	localparam int DEPTH       = 256;
	localparam int SETTLE      = 6000;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [LAG_W-1:0] lag;
		logic [ACV_W-1:0] acv;
		logic             last;
	} acv_result_t;

	// One row of the directed table: a register write or a closing price.
	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		int unsigned           val;
		int                    runs;   // results per bar, or -1 when left to the calculator
	} bar_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Mirror of the unit's state and registers.
	logic signed [RET_W-1:0] return_hist [DEPTH];
	logic [7:0]              hist_ptr;
	int                      hist_count;
	logic [CLOSE_W-1:0]      last_close;
	bit                      have_close;
	logic [WIN_W-1:0]        win_reg;
	logic [LAG_W-1:0]        lag_reg;

	acv_result_t pending_acv[$];
	int          errors;
	int          cycles;
	int          burst_left;
	int          stall_left;
	int          mode_left;
	bit          stall_mode;

	return_autocovariance_window_unit #(.RING_DEPTH(DEPTH)) DUT (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
	endtask

	// Works out the autocovariance run caused by one bar and queues it.
	task automatic predict_bar(input logic [CLOSE_W-1:0] close, output int cnt);
		int n, lags, base;
		logic signed [127:0] mean_sum, acc, mag, q, divisor;
		logic signed [127:0] dev [DEPTH];
		logic [ACV_W-1:0] v;
		bit neg;
		acv_result_t r;
		cnt = 0;
		if (have_close) begin
			return_hist[hist_ptr] = {1'b0, close} - {1'b0, last_close};
			hist_ptr++;
			if (hist_count < DEPTH)
				hist_count++;
		end
		last_close = close;
		have_close = 1'b1;
		n = int'(win_reg) + 1;
		if (n > hist_count)
			n = hist_count;
		if (n < MIN_RETURNS)
			return;
		base = (int'(hist_ptr) + 2 * DEPTH - n) % DEPTH;
		mean_sum = 0;
		for (int k = 0; k < n; k++)
			mean_sum += return_hist[(base + k) % DEPTH];
		// Deviations scaled by n keep the mean exact.
		for (int k = 0; k < n; k++)
			dev[k] = 128'sd0 + n * return_hist[(base + k) % DEPTH] - mean_sum;
		lags = (lag_reg > LAG_CAP) ? int'(LAG_CAP) : int'(lag_reg);
		for (int lag = 1; lag <= lags; lag++) begin
			if (n - lag < 2)
				break;
			acc = 0;
			for (int k = lag; k < n; k++)
				acc += dev[k] * dev[k - lag];
			neg = acc < 0;
			mag = (neg ? -acc : acc) <<< FRAC_BITS;
			divisor = 128'sd0 + n * n * (n - lag);
			q = mag / divisor;
			if (neg) begin
				v = (q > (128'sd1 <<< 56)) ? (57'd1 << 56) : q[ACV_W-1:0];
				v = -v;
			end else begin
				v = (q > ((128'sd1 <<< 56) - 1)) ? {1'b0, {56{1'b1}}} : q[ACV_W-1:0];
			end
			r.lag  = lag[LAG_W-1:0];
			r.acv  = v;
			r.last = 1'b0;
			pending_acv.push_back(r);
			cnt++;
		end
		if (cnt > 0)
			pending_acv[pending_acv.size() - 1].last = 1'b1;
	endtask

	// Offers one price, waits for the transfer, then plans the next gap.
	task automatic send_bar(input logic [CLOSE_W-1:0] close, output int cnt);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= close;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_bar(close, cnt);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// Register writes wait until the unit has drained and settled.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		s_axis_tvalid <= 1'b0;
		while (pending_acv.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		if (idx == REG_WINDOW_BARS)
			win_reg = val[WIN_W-1:0];
		else
			lag_reg = val[LAG_W-1:0];
		cfg_we <= 1'b0;
	endtask

	// Receiver ready pattern: stretches of full flow and stretches of stalls.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 1);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (!stall_mode) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		acv_result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_acv.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata, 64'd0);
			end else begin
				want = pending_acv.pop_front();
				if (m_axis_tdata[2:0] !== want.lag)
					report_mismatch("lag_index", m_axis_tdata[2:0], want.lag);
				if (m_axis_tdata[59:3] !== want.acv)
					report_mismatch("autocovariance", m_axis_tdata[59:3], want.acv);
				if (m_axis_tdata[63:60] !== 4'd0)
					report_mismatch("padding", m_axis_tdata[63:60], 64'd0);
				if (m_axis_tlast !== want.last)
					report_mismatch("tlast", m_axis_tlast, want.last);
			end
		end
	end

	initial begin
		bar_row_t plan [$];
		int cnt, win, mode;
		logic [CLOSE_W-1:0] price;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		errors        = 0;
		cycles        = 0;
		burst_left    = 0;
		stall_left    = 0;
		mode_left     = 0;
		stall_mode    = 1'b0;
		hist_ptr      = '0;
		hist_count    = 0;
		last_close    = '0;
		have_close    = 1'b0;
		win_reg       = WINDOW_BARS_RST;
		lag_reg       = MAX_LAG_RST;

		// Directed part: first bar, short history, full-scale price extremes,
		// max_lag zero and above five, and windows too short for any lag.
		plan = '{
			'{0, REG_WINDOW_BARS, 24'd0,       0},
			'{0, REG_WINDOW_BARS, 24'hFFFFFF,  0},
			'{0, REG_WINDOW_BARS, 24'd0,       0},
			'{0, REG_WINDOW_BARS, 24'hFFFFFF,  1},
			'{1, REG_WINDOW_BARS, 3,          -1},
			'{1, REG_MAX_LAG,     7,          -1},
			'{0, REG_WINDOW_BARS, 24'd0,       2},
			'{0, REG_WINDOW_BARS, 24'hFFFFFF,  2},
			'{1, REG_MAX_LAG,     0,          -1},
			'{0, REG_WINDOW_BARS, 24'd5,       0},
			'{1, REG_MAX_LAG,     5,          -1},
			'{1, REG_WINDOW_BARS, 255,        -1},
			'{0, REG_WINDOW_BARS, 24'd100,    -1},
			'{0, REG_WINDOW_BARS, 24'd99,     -1},
			'{0, REG_WINDOW_BARS, 24'd123456, -1},
			'{1, REG_WINDOW_BARS, 0,          -1},
			'{0, REG_WINDOW_BARS, 24'd7,       0},
			'{1, REG_WINDOW_BARS, 1,          -1},
			'{0, REG_WINDOW_BARS, 24'd9,       0},
			'{1, REG_WINDOW_BARS, 2,          -1},
			'{0, REG_WINDOW_BARS, 24'h800000,  1}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_bar(plan[i].val[CLOSE_W-1:0], cnt);
				if (plan[i].runs >= 0 && cnt != plan[i].runs)
					report_mismatch("results per bar", cnt, plan[i].runs);
			end
		end

		// Random phases: mostly short windows, with a long one now and then.
		price = 24'd8000000;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 5))
				0: win = 255;
				1: win = $urandom_range(0, 255);
				2: win = $urandom_range(0, 2);
				default: win = $urandom_range(3, 12);
			endcase
			if (ph == 7)
				win = 255;
			write_reg(REG_WINDOW_BARS, win);
			write_reg(REG_MAX_LAG, $urandom_range(0, 7));
			mode = $urandom_range(0, 2);
			for (int b = 0; b < 13; b++) begin
				case (mode)
					0: price = price + $urandom_range(0, 2000) - 1000;
					1: price = $urandom();
					default: price = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
				endcase
				send_bar(price, cnt);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_acv.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
